>>> hw/rtl/lsgj_pkg.sv
// Shared definitions for the Gauss-Jordan linear system solver.
// Field widths, command and register codes, and the sequencer state type.
// No dependencies.
package lsgj_pkg;

  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int VAL_W     = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int DATA_W    = 40;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = VAL_W + FRAC_W;

  // Input transaction kinds
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RHS_COUNT   = 1'b1;

  typedef enum logic [24:0] {
    ST_IDLE     = 25'h0000001,
    ST_CP_RD    = 25'h0000002,
    ST_CP_WR    = 25'h0000004,
    ST_SR_INIT  = 25'h0000008,
    ST_SR_RD    = 25'h0000010,
    ST_SR_CMP   = 25'h0000020,
    ST_SW_RA    = 25'h0000040,
    ST_SW_RB    = 25'h0000080,
    ST_SW_WA    = 25'h0000100,
    ST_SW_WB    = 25'h0000200,
    ST_NM_RD    = 25'h0000400,
    ST_NM_LD    = 25'h0000800,
    ST_NM_DIV   = 25'h0001000,
    ST_NM_WR    = 25'h0002000,
    ST_EL_FRD   = 25'h0004000,
    ST_EL_F     = 25'h0008000,
    ST_EL_RA    = 25'h0010000,
    ST_EL_RB    = 25'h0020000,
    ST_EL_MUL   = 25'h0040000,
    ST_EL_ADJ   = 25'h0080000,
    ST_EL_WR    = 25'h0100000,
    ST_PIV_NEXT = 25'h0200000,
    ST_OUT_RD   = 25'h0400000,
    ST_OUT_LD   = 25'h0800000,
    ST_OUT_WAIT = 25'h1000000
  } state_t;

endpackage

>>> hw/rtl/linear_system_solver_gauss_jordan_unit.sv
// Gauss-Jordan solver with partial pivoting on signed Q16.16 values.
// Uses lsgj_pkg for field widths, codes and the sequencer state type.
//
// Usage:
//   Slave stream: s_tuser carries the command (load A entry, load B entry,
//   solve); s_tdata carries row, col and value. Loads leave the block idle.
//   A solve copies the stores into a work memory, eliminates column by
//   column and streams X = A^-1 B row-major on the master stream, one
//   transaction per entry, m_tlast on the final one, m_tuser = singular.
//   For each pivot column the solve runs a pivot search, a row swap
//   when needed, normalize of the pivot row and elimination of every
//   other row; a zero pivot sets singular and skips to the next column.
//   Output follows the last column. Normalize uses a bit-serial
//   restoring divider, and the work memory has a single read port.
//   s_tready is high only while idle; the block takes nothing during a
//   solve. A stalled m_tready holds the current result and the sequencer.
//   Reset (rst, synchronous) returns to idle, sets both sizes to 8 and
//   clears the singular flag; store contents are kept and must be loaded
//   before use.
module linear_system_solver_gauss_jordan_unit #(
  parameter int MAX_SIZE = 8,
  parameter int MAX_RHS  = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lsgj_pkg::DATA_W-1:0]     s_tdata,   // row[2:0], col[5:3], value[37:6]
  input  logic [lsgj_pkg::CMD_W-1:0]      s_tuser,   // cmd[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lsgj_pkg::DATA_W-1:0]     m_tdata,   // out_row[2:0], out_col[5:3], solution[37:6]
  output logic                            m_tuser,   // singular[0]
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [lsgj_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [lsgj_pkg::CFG_W-1:0]      cfg_data
);
  import lsgj_pkg::*;

  localparam int WC    = MAX_SIZE + MAX_RHS;
  localparam int CW    = $clog2(WC);
  localparam int MDEP  = MAX_SIZE * MAX_SIZE;
  localparam int RDEP  = MAX_SIZE * MAX_RHS;
  localparam int WDEP  = MAX_SIZE * WC;
  localparam int MAW   = (MDEP > 1) ? $clog2(MDEP) : 1;
  localparam int RAW   = (RDEP > 1) ? $clog2(RDEP) : 1;
  localparam int WAW   = $clog2(WDEP);

  state_t               state;
  logic [CFG_W-1:0]     matrix_size;
  logic [CFG_W-1:0]     rhs_count;
  logic [ROW_W-1:0]     n_last;
  logic [ROW_W-1:0]     r_last;
  logic [ROW_W-1:0]     n_last_calc;
  logic [ROW_W-1:0]     r_last_calc;
  logic                 singular;

  logic [ROW_W-1:0]     ri;
  logic [ROW_W-1:0]     rk;
  logic [ROW_W-1:0]     best;
  logic [CW-1:0]        cj;
  logic [VAL_W-1:0]     bestmag;
  logic [VAL_W-1:0]     bestval;
  logic [VAL_W-1:0]     tmp;

  logic [ROW_W-1:0]     in_row;
  logic [COL_W-1:0]     in_col;
  logic [VAL_W-1:0]     in_value;
  logic                 in_acc;

  logic [VAL_W-1:0]     mstore [MDEP];
  logic [VAL_W-1:0]     rstore [RDEP];
  logic [VAL_W-1:0]     wmem   [WDEP];
  logic                 m_we, r_we;
  logic [MAW-1:0]       m_waddr, m_raddr;
  logic [RAW-1:0]       r_waddr, r_raddr;
  logic [VAL_W-1:0]     m_rdata, r_rdata;
  logic                 w_we;
  logic [WAW-1:0]       w_waddr, w_raddr;
  logic [VAL_W-1:0]     w_wdata, w_rdata;

  logic [CW-1:0]        col_next;
  logic                 col_last;
  logic [VAL_W-1:0]     rd_mag;
  logic                 mag_win;
  logic [VAL_W-1:0]     final_mag;
  logic [ROW_W-1:0]     final_best;
  logic [ROW_W:0]       k_inc, k_skip;
  logic                 elim_done;

  logic [QUO_W-1:0]     div_quo;
  logic [VAL_W-1:0]     div_rem;
  logic [VAL_W-1:0]     div_dmag;
  logic                 div_neg;
  logic [5:0]           div_cnt;
  logic [VAL_W:0]       div_part, div_trial;
  logic                 div_fit;
  logic [VAL_W-1:0]     div_res;
  logic [VAL_W-1:0]     piv_mag;

  logic signed [VAL_W-1:0]   fct, bop, aop;
  logic signed [2*VAL_W-1:0] prod;
  logic [2*VAL_W-1:0]        prod_adj;
  logic signed [QUO_W-1:0]   elq;
  logic [QUO_W:0]            diff;
  logic [VAL_W-1:0]          sub_res;

  function automatic logic [WAW-1:0] waddr_f(input logic [ROW_W-1:0] r,
                                             input logic [CW-1:0] c);
    return WAW'(r) * WAW'(WC) + WAW'(c);
  endfunction

  // Unpack the input transaction
  assign in_row   = s_tdata[2:0];
  assign in_col   = s_tdata[5:3];
  assign in_value = s_tdata[37:6];
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // Clamp sizes to 1..max, kept as last index
  always_comb begin
    if (matrix_size == '0) n_last_calc = '0;
    else if (matrix_size > CFG_W'(MAX_SIZE)) n_last_calc = ROW_W'(MAX_SIZE - 1);
    else n_last_calc = ROW_W'(matrix_size - 4'd1);
    if (rhs_count == '0) r_last_calc = '0;
    else if (rhs_count > CFG_W'(MAX_RHS)) r_last_calc = ROW_W'(MAX_RHS - 1);
    else r_last_calc = ROW_W'(rhs_count - 4'd1);
  end

  // Load stores
  assign m_we    = in_acc && (s_tuser == CMD_LOAD_A) && ({1'b0, in_row} < 4'(MAX_SIZE))
                   && ({1'b0, in_col} < 4'(MAX_SIZE));
  assign r_we    = in_acc && (s_tuser == CMD_LOAD_B) && ({1'b0, in_row} < 4'(MAX_SIZE))
                   && ({1'b0, in_col} < 4'(MAX_RHS));
  assign m_waddr = MAW'(in_row) * MAW'(MAX_SIZE) + MAW'(in_col);
  assign r_waddr = RAW'(in_row) * RAW'(MAX_RHS) + RAW'(in_col);
  assign m_raddr = MAW'(ri) * MAW'(MAX_SIZE) + MAW'(cj);
  assign r_raddr = RAW'(ri) * RAW'(MAX_RHS) + RAW'(cj - CW'(MAX_SIZE));

  always_ff @(posedge clk) begin
    if (m_we) mstore[m_waddr] <= in_value;
    m_rdata <= mstore[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) rstore[r_waddr] <= in_value;
    r_rdata <= rstore[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata <= wmem[w_raddr];
  end

  // Walk active columns: A columns up to n-1, then B columns
  assign col_next = (cj == CW'(n_last)) ? CW'(MAX_SIZE) : cj + CW'(1);
  assign col_last = (cj == CW'(MAX_SIZE) + CW'(r_last));

  // Pivot magnitude compare
  assign rd_mag     = w_rdata[VAL_W-1] ? (~w_rdata + 32'd1) : w_rdata;
  assign mag_win    = rd_mag > bestmag;
  assign final_mag  = mag_win ? rd_mag : bestmag;
  assign final_best = mag_win ? rk : best;
  assign piv_mag    = bestval[VAL_W-1] ? (~bestval + 32'd1) : bestval;

  // Next elimination row, skipping the pivot row
  assign k_inc     = {1'b0, rk} + 4'd1;
  assign k_skip    = (k_inc == {1'b0, ri}) ? k_inc + 4'd1 : k_inc;
  assign elim_done = k_skip > {1'b0, n_last};

  // Bit-serial restoring divider step and result saturation
  assign div_part  = {div_rem, div_quo[QUO_W-1]};
  assign div_fit   = div_part >= {1'b0, div_dmag};
  assign div_trial = div_part - {1'b0, div_dmag};
  always_comb begin
    if (div_neg) begin
      div_res = (div_quo > 48'h0000_8000_0000) ? 32'h8000_0000
                                               : (~div_quo[VAL_W-1:0] + 32'd1);
    end else begin
      div_res = (div_quo > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[VAL_W-1:0];
    end
  end

  // Multiply-subtract: truncate product toward zero, subtract, saturate
  assign prod_adj = prod[2*VAL_W-1] ? (prod + 64'd65535) : prod;
  assign diff     = {{(FRAC_W+1){aop[VAL_W-1]}}, aop} - {elq[QUO_W-1], elq};
  always_comb begin
    if (diff[QUO_W:VAL_W-1] == '0 || diff[QUO_W:VAL_W-1] == '1) sub_res = diff[VAL_W-1:0];
    else if (diff[QUO_W]) sub_res = 32'h8000_0000;
    else sub_res = 32'h7FFF_FFFF;
  end

  // Work memory port selection
  always_comb begin
    w_we    = 1'b0;
    w_waddr = waddr_f(ri, cj);
    w_wdata = w_rdata;
    w_raddr = waddr_f(ri, cj);
    unique case (state)
      ST_CP_WR: begin
        w_we    = 1'b1;
        w_wdata = (cj < CW'(MAX_SIZE)) ? m_rdata : r_rdata;
      end
      ST_SR_RD:  w_raddr = waddr_f(rk, CW'(ri));
      ST_SW_RB:  w_raddr = waddr_f(best, cj);
      ST_SW_WA:  w_we = 1'b1;
      ST_SW_WB: begin
        w_we    = 1'b1;
        w_waddr = waddr_f(best, cj);
        w_wdata = tmp;
      end
      ST_NM_WR: begin
        w_we    = 1'b1;
        w_wdata = div_res;
      end
      ST_EL_FRD: w_raddr = waddr_f(rk, CW'(ri));
      ST_EL_RB:  w_raddr = waddr_f(rk, cj);
      ST_EL_WR: begin
        w_we    = 1'b1;
        w_waddr = waddr_f(rk, cj);
        w_wdata = sub_res;
      end
      default: ;
    endcase
  end

  // Elimination datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_EL_F) fct <= w_rdata;
    if (state == ST_EL_RB) bop <= w_rdata;
    if (state == ST_EL_MUL) begin
      aop  <= w_rdata;
      prod <= fct * bop;
    end
    if (state == ST_EL_ADJ) elq <= prod_adj[2*VAL_W-1:FRAC_W];
    if (state == ST_SW_RB) tmp <= w_rdata;
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (state == ST_NM_LD) begin
      div_quo  <= {(w_rdata[VAL_W-1] ? (~w_rdata + 32'd1) : w_rdata), 16'd0};
      div_rem  <= '0;
      div_dmag <= piv_mag;
      div_neg  <= w_rdata[VAL_W-1] ^ bestval[VAL_W-1];
    end else if (state == ST_NM_DIV) begin
      div_rem <= div_fit ? div_trial[VAL_W-1:0] : div_part[VAL_W-1:0];
      div_quo <= {div_quo[QUO_W-2:0], div_fit};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      singular    <= 1'b0;
      matrix_size <= 4'd8;
      rhs_count   <= 4'd8;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MATRIX_SIZE: matrix_size <= cfg_data;
          REG_RHS_COUNT:   rhs_count   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && s_tuser == CMD_SOLVE) begin
            n_last   <= n_last_calc;
            r_last   <= r_last_calc;
            singular <= 1'b0;
            ri       <= '0;
            cj       <= '0;
            state    <= ST_CP_RD;
          end
        end
        ST_CP_RD: state <= ST_CP_WR;
        ST_CP_WR: begin
          if (col_last) begin
            cj <= '0;
            if (ri == n_last) begin
              ri    <= '0;
              state <= ST_SR_INIT;
            end else begin
              ri    <= ri + 3'd1;
              state <= ST_CP_RD;
            end
          end else begin
            cj    <= col_next;
            state <= ST_CP_RD;
          end
        end
        ST_SR_INIT: begin
          rk      <= ri;
          best    <= ri;
          bestmag <= '0;
          state   <= ST_SR_RD;
        end
        ST_SR_RD: state <= ST_SR_CMP;
        ST_SR_CMP: begin
          if (mag_win) begin
            bestmag <= rd_mag;
            best    <= rk;
            bestval <= w_rdata;
          end
          if (rk == n_last) begin
            if (final_mag == '0) begin
              singular <= 1'b1;
              state    <= ST_PIV_NEXT;
            end else if (final_best != ri) begin
              cj    <= '0;
              state <= ST_SW_RA;
            end else begin
              cj    <= CW'(ri);
              state <= ST_NM_RD;
            end
          end else begin
            rk    <= rk + 3'd1;
            state <= ST_SR_RD;
          end
        end
        ST_SW_RA: state <= ST_SW_RB;
        ST_SW_RB: state <= ST_SW_WA;
        ST_SW_WA: state <= ST_SW_WB;
        ST_SW_WB: begin
          if (col_last) begin
            cj    <= CW'(ri);
            state <= ST_NM_RD;
          end else begin
            cj    <= col_next;
            state <= ST_SW_RA;
          end
        end
        ST_NM_RD: state <= ST_NM_LD;
        ST_NM_LD: begin
          div_cnt <= 6'd47;
          state   <= ST_NM_DIV;
        end
        ST_NM_DIV: begin
          if (div_cnt == '0) state <= ST_NM_WR;
          else div_cnt <= div_cnt - 6'd1;
        end
        ST_NM_WR: begin
          if (col_last) begin
            if (n_last == '0) begin
              state <= ST_PIV_NEXT;
            end else begin
              rk    <= (ri == '0) ? 3'd1 : 3'd0;
              state <= ST_EL_FRD;
            end
          end else begin
            cj    <= col_next;
            state <= ST_NM_RD;
          end
        end
        ST_EL_FRD: state <= ST_EL_F;
        ST_EL_F: begin
          cj    <= CW'(ri);
          state <= ST_EL_RA;
        end
        ST_EL_RA:  state <= ST_EL_RB;
        ST_EL_RB:  state <= ST_EL_MUL;
        ST_EL_MUL: state <= ST_EL_ADJ;
        ST_EL_ADJ: state <= ST_EL_WR;
        ST_EL_WR: begin
          if (col_last) begin
            if (elim_done) begin
              state <= ST_PIV_NEXT;
            end else begin
              rk    <= k_skip[ROW_W-1:0];
              state <= ST_EL_FRD;
            end
          end else begin
            cj    <= col_next;
            state <= ST_EL_RA;
          end
        end
        ST_PIV_NEXT: begin
          if (ri == n_last) begin
            ri    <= '0;
            cj    <= CW'(MAX_SIZE);
            state <= ST_OUT_RD;
          end else begin
            ri    <= ri + 3'd1;
            state <= ST_SR_INIT;
          end
        end
        ST_OUT_RD: state <= ST_OUT_LD;
        ST_OUT_LD: begin
          m_tdata  <= {2'b00, w_rdata, 3'(cj - CW'(MAX_SIZE)), ri};
          m_tuser  <= singular;
          m_tlast  <= (ri == n_last) && col_last;
          m_tvalid <= 1'b1;
          state    <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (ri == n_last && col_last) begin
              state <= ST_IDLE;
            end else begin
              if (col_last) begin
                cj <= CW'(MAX_SIZE);
                ri <= ri + 3'd1;
              end else begin
                cj <= col_next;
              end
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/lsgj_checker.sv
// Port-level checks for the Gauss-Jordan solver, bound to its top level.
// Uses lsgj_pkg for widths and command codes.
module lsgj_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [lsgj_pkg::CMD_W-1:0]      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lsgj_pkg::DATA_W-1:0]     m_tdata,
  input logic                            m_tlast
);
  import lsgj_pkg::*;

  // Never accept input while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input ready while result pending");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Solve transaction makes the block busy
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_SOLVE |=> !s_tready)
    else $error("still ready after solve");

  // Loads and other non-solve commands leave the block ready
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != CMD_SOLVE |=> s_tready)
    else $error("not ready after load");

  // Final result returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("not idle after last result");

endmodule

bind linear_system_solver_gauss_jordan_unit lsgj_checker u_lsgj_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
